// ===== rtl/core/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    // Request controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Request type codes.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Configuration register max_entries.
    localparam int              MAX_ENTRIES_W     = 5;
    localparam logic [4:0]      MAX_ENTRIES_RESET = 5'd16;
    localparam int              APB_DATA_W        = 32;

    // Widest slot index and recency rank over the supported entry counts (up to 64).
    localparam int SLOT_MAX_W = 6;
    localparam int RANK_MAX_W = 7;

    // Promotion command from the request controller to the recency tracker.
    typedef struct packed {
        logic                  en;     // apply a promotion this cycle
        logic                  fresh;  // slot becomes valid (insert into an empty slot)
        logic [SLOT_MAX_W-1:0] slot;   // slot that becomes most recent
        logic [RANK_MAX_W-1:0] rank;   // previous rank of that slot
    } promote_cmd_t;

endpackage

// ===== rtl/core/lkv_store.sv =====
// Key and value storage: a synchronous single-write, single-read memory.
module lkv_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_value,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_value
);

    logic [KEY_BITS+VALUE_BITS-1:0] mem [ENTRIES];
    logic [KEY_BITS+VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_value};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_value = rd_data_reg[VALUE_BITS-1:0];

endmodule

// ===== rtl/core/lkv_rank.sv =====
// Valid bits and recency ranks of all slots, with the promotion update.
module lkv_rank #(
    parameter int ENTRIES = 16,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int RANK_W = $clog2(ENTRIES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lkv_pkg::promote_cmd_t cmd,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic [RANK_W-1:0]    rd_rank,
    output logic [ENTRIES-1:0]   valid_vec
);

    localparam int SLOT_W = lkv_pkg::SLOT_MAX_W;

    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    // Promotion: the chosen slot becomes rank zero, and every other valid slot
    // that was more recent than it ages by one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (cmd.en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (cmd.slot == SLOT_W'(i)) begin
                    rank_reg[i]  <= '0;
                    valid_reg[i] <= 1'b1;
                end else if (valid_reg[i] && (rank_reg[i] < cmd.rank[RANK_W-1:0])) begin
                    rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    assign rd_rank   = rank_reg[rd_idx];
    assign valid_vec = valid_reg;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Requests are processed one at a time: a new request is accepted only in the idle state.
// Each request passes through a scan, in which the single memory read port walks every
// slot once and the compare of the last slot trails the final read, then a write-back
// state that waits while the result register is full, then idle, where the next one is accepted.
// Reset: synchronous, active low; clears valid bits, ranks, occupancy and sets
// max_entries to 16. The key/value memory is not cleared; its contents are used only for valid slots.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Request channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_value,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [VALUE_BITS-1:0] m_read_value
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = $clog2(ENTRIES + 1);
    localparam int MEW    = lkv_pkg::MAX_ENTRIES_W;
    localparam int CMP_W  = (CNT_W > MEW) ? CNT_W : MEW;

    // Control state.
    lkv_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               cmp_pend_reg, cmp_pend_next;
    logic               found_reg, found_next;
    logic               free_reg, free_next;
    logic               evict_reg, evict_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [MEW-1:0]     max_entries_reg, max_entries_next;
    logic               m_valid_reg, m_valid_next;

    // Payload state.
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  req_put_reg, req_put_next;
    logic [KEY_BITS-1:0]   req_key_reg, req_key_next;
    logic [VALUE_BITS-1:0] req_value_reg, req_value_next;
    logic [IDX_W-1:0]      found_idx_reg, found_idx_next;
    logic [RANK_W-1:0]     found_rank_reg, found_rank_next;
    logic [VALUE_BITS-1:0] found_value_reg, found_value_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      evict_idx_reg, evict_idx_next;
    logic [RANK_W-1:0]     evict_rank_reg, evict_rank_next;
    logic                  m_hit_reg, m_hit_next;
    logic [VALUE_BITS-1:0] m_read_value_reg, m_read_value_next;

    // Memory and tracker connections.
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [RANK_W-1:0]     rd_rank;
    logic [ENTRIES-1:0]    valid_vec;
    lkv_pkg::promote_cmd_t promote_cmd;

    // Scan and write-back helpers.
    logic                  s_fire;
    logic                  cfg_write;
    logic                  slot_valid;
    logic                  entry_match;
    logic                  advance;
    logic [CMP_W-1:0]      cap;
    logic [CMP_W-1:0]      max_ext;
    logic                  use_free;
    logic                  do_promote;
    logic                  fresh;
    logic [IDX_W-1:0]      slot_sel;
    logic [RANK_W-1:0]     slot_rank;

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (req_key_reg),
        .wr_value (req_value_reg)
    );

    lkv_rank #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (promote_cmd),
        .rd_idx    (cmp_idx_reg),
        .rd_rank   (rd_rank),
        .valid_vec (valid_vec)
    );

    // The register file holds one register, so every address selects max_entries.
    assign pready    = 1'b1;
    assign prdata    = {{(lkv_pkg::APB_DATA_W - MEW){1'b0}}, max_entries_reg};
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_ready      = (state_reg == lkv_pkg::ST_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

    // A result can be loaded when the output register is empty or being drained.
    assign advance = !m_valid_reg || m_ready;

    // The memory read port walks every slot in turn; the comparison runs in the cycle after each read.
    assign rd_en       = (state_reg == lkv_pkg::ST_SCAN) && (iss_reg != CNT_W'(ENTRIES));
    assign rd_addr     = iss_reg[IDX_W-1:0];
    assign slot_valid  = valid_vec[cmp_idx_reg];
    assign entry_match = cmp_pend_reg && slot_valid && (rd_key == req_key_reg);

    // Effective capacity: zero counts as one and anything above the slot count is clipped.
    assign max_ext = CMP_W'(max_entries_reg);
    always_comb begin
        if (max_entries_reg == '0) begin
            cap = CMP_W'(1);
        end else if (max_ext > CMP_W'(ENTRIES)) begin
            cap = CMP_W'(ENTRIES);
        end else begin
            cap = max_ext;
        end
    end

    // Target slot for the write-back: the hit slot, else a free slot while below
    // capacity, else the least recently used valid slot.
    assign use_free = (CMP_W'(used_reg) < cap) && free_reg;
    always_comb begin
        fresh     = 1'b0;
        slot_sel  = '0;
        slot_rank = RANK_W'(ENTRIES);
        priority if (found_reg) begin
            slot_sel  = found_idx_reg;
            slot_rank = found_rank_reg;
        end else if (use_free) begin
            slot_sel = free_idx_reg;
            fresh    = 1'b1;
        end else if (evict_reg) begin
            slot_sel  = evict_idx_reg;
            slot_rank = evict_rank_reg;
        end else begin
            fresh = 1'b1;
        end
    end

    assign do_promote = (state_reg == lkv_pkg::ST_WRITE) && advance
                        && (found_reg || (req_put_reg == lkv_pkg::REQ_PUT));
    assign wr_en      = (state_reg == lkv_pkg::ST_WRITE) && advance
                        && (req_put_reg == lkv_pkg::REQ_PUT);
    assign wr_addr    = slot_sel;

    always_comb begin
        promote_cmd       = '0;
        promote_cmd.en    = do_promote;
        promote_cmd.fresh = fresh && !found_reg;
        promote_cmd.slot[IDX_W-1:0]  = slot_sel;
        promote_cmd.rank[RANK_W-1:0] = slot_rank;
    end

    // Next-state and datapath control.
    always_comb begin
        state_next        = state_reg;
        iss_next          = iss_reg;
        cmp_pend_next     = 1'b0;
        found_next        = found_reg;
        free_next         = free_reg;
        evict_next        = evict_reg;
        used_next         = used_reg;
        max_entries_next  = max_entries_reg;
        m_valid_next      = m_valid_reg;
        cmp_idx_next      = cmp_idx_reg;
        req_put_next      = req_put_reg;
        req_key_next      = req_key_reg;
        req_value_next    = req_value_reg;
        found_idx_next    = found_idx_reg;
        found_rank_next   = found_rank_reg;
        found_value_next  = found_value_reg;
        free_idx_next     = free_idx_reg;
        evict_idx_next    = evict_idx_reg;
        evict_rank_next   = evict_rank_reg;
        m_hit_next        = m_hit_reg;
        m_read_value_next = m_read_value_reg;

        if (cfg_write) begin
            max_entries_next = pwdata[MEW-1:0];
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_fire) begin
                    req_put_next   = s_req_type;
                    req_key_next   = s_key;
                    req_value_next = s_value;
                    iss_next       = '0;
                    found_next     = 1'b0;
                    free_next      = 1'b0;
                    evict_next     = 1'b0;
                    state_next     = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (rd_en) begin
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = rd_addr;
                    iss_next      = iss_reg + CNT_W'(1);
                end else begin
                    state_next = lkv_pkg::ST_WRITE;
                end
                // Keep the first match, the first empty slot and the oldest valid slot.
                if (entry_match && !found_reg) begin
                    found_next       = 1'b1;
                    found_idx_next   = cmp_idx_reg;
                    found_rank_next  = rd_rank;
                    found_value_next = rd_value;
                end
                if (cmp_pend_reg && !slot_valid && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                if (cmp_pend_reg && slot_valid && (!evict_reg || (rd_rank > evict_rank_reg))) begin
                    evict_next      = 1'b1;
                    evict_idx_next  = cmp_idx_reg;
                    evict_rank_next = rd_rank;
                end
            end
            lkv_pkg::ST_WRITE: begin
                if (advance) begin
                    m_valid_next      = 1'b1;
                    m_hit_next        = found_reg;
                    m_read_value_next = (found_reg && (req_put_reg == lkv_pkg::REQ_GET))
                                        ? found_value_reg : '0;
                    if (!found_reg && (req_put_reg == lkv_pkg::REQ_PUT) && fresh) begin
                        used_next = used_reg + CNT_W'(1);
                    end
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lkv_pkg::ST_IDLE;
            iss_reg         <= '0;
            cmp_pend_reg    <= 1'b0;
            found_reg       <= 1'b0;
            free_reg        <= 1'b0;
            evict_reg       <= 1'b0;
            used_reg        <= '0;
            max_entries_reg <= lkv_pkg::MAX_ENTRIES_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            iss_reg         <= iss_next;
            cmp_pend_reg    <= cmp_pend_next;
            found_reg       <= found_next;
            free_reg        <= free_next;
            evict_reg       <= evict_next;
            used_reg        <= used_next;
            max_entries_reg <= max_entries_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg      <= cmp_idx_next;
        req_put_reg      <= req_put_next;
        req_key_reg      <= req_key_next;
        req_value_reg    <= req_value_next;
        found_idx_reg    <= found_idx_next;
        found_rank_reg   <= found_rank_next;
        found_value_reg  <= found_value_next;
        free_idx_reg     <= free_idx_next;
        evict_idx_reg    <= evict_idx_next;
        evict_rank_reg   <= evict_rank_next;
        m_hit_reg        <= m_hit_next;
        m_read_value_reg <= m_read_value_next;
    end

    // The occupancy counter always matches the number of valid slots.
    a_used_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == used_reg)
        else $error("occupancy count differs from the number of valid slots");

    // A miss never carries a value.
    a_miss_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_read_value_reg == '0))
        else $error("miss result carries a nonzero value");

    // A recorded hit always points at a valid slot.
    a_found_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> valid_vec[found_idx_reg])
        else $error("hit recorded on an invalid slot");

    // The memory and the recency ranks are never updated while the key walk is in progress.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lkv_pkg::ST_SCAN) |-> (!wr_en && !promote_cmd.en))
        else $error("state update during the key walk");

endmodule
